// File: hw/rtl/bocu1_pkg.sv
`timescale 1ns / 1ps
// bocu1_pkg: shared types, constants and helper functions of the bocu-1 decoder
// no dependencies; used by every module of the decoder
package bocu1_pkg;

   // widths
   localparam int BYTE_W  = 8;
   localparam int CP_W    = 21;
   localparam int STAT_W  = 2;
   localparam int DIFF_W  = 25;   // signed difference, magnitude below 2^24
   localparam int SUM_W   = DIFF_W + 1;

   localparam int QUEUE_DEPTH = 4;

   // result status codes
   localparam logic [STAT_W-1:0] STATUS_CP  = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EOT = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_ERR = 2'd2;

   // scheme constants
   localparam logic [CP_W-1:0] ASCII_BASE = 21'h40;
   localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;

   localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
   localparam logic [BYTE_W-1:0] RESET_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] MID_BYTE   = 8'h90;
   localparam logic [BYTE_W-1:0] MIN_LEAD   = 8'h21;
   localparam logic [BYTE_W-1:0] POS2_LEAD  = 8'hD0;
   localparam logic [BYTE_W-1:0] POS3_LEAD  = 8'hFB;
   localparam logic [BYTE_W-1:0] POS4_LEAD  = 8'hFE;
   localparam logic [BYTE_W-1:0] NEG2_LEAD  = 8'h50;
   localparam logic [BYTE_W-1:0] NEG3_LEAD  = 8'h25;
   localparam logic [BYTE_W-1:0] TRAIL_OFS  = 8'h0D;

   localparam int TRAIL_RADIX  = 243;
   localparam int TRAIL_RADIX2 = TRAIL_RADIX * TRAIL_RADIX;
   localparam int TRAIL_RADIX3 = TRAIL_RADIX2 * TRAIL_RADIX;
   localparam int POS_REACH1   = 63;
   localparam int NEG_REACH1   = -64;
   localparam int POS_REACH2   = 10512;
   localparam int NEG_REACH2   = -10513;
   localparam int POS_REACH3   = 187659;
   localparam int NEG_REACH3   = -187660;

   // operations handed from the front to the back
   typedef enum logic [2:0] {
      OP_CHAR,   // pass a control code or space through
      OP_EOT,    // end of text
      OP_ERR,    // decode error
      OP_DIFF,   // add a difference to the base
      OP_BASE    // reset the base, no result
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DIFF_W-1:0] arg;   // difference, or the byte for pass-through
      logic                     clr;   // reset the base after this transaction
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef struct packed {
      logic             ok;
      logic [BYTE_W-1:0] val;
   } trail_type;

   // trail value of a trail byte; control codes map through a sparse table
   function automatic trail_type trail_value(input logic [BYTE_W-1:0] b);
      trail_type r;
      r.ok  = 1'b1;
      r.val = b - TRAIL_OFS;
      if (b <= SPACE_BYTE) begin
         case (b) inside
            [8'h01:8'h06]: r.val = b - 8'd1;
            [8'h10:8'h19]: r.val = b - 8'd10;
            [8'h1C:8'h1F]: r.val = b - 8'd12;
            default: begin
               r.ok  = 1'b0;
               r.val = '0;
            end
         endcase
      end
      return r;
   endfunction

   // base for the next character, from the one just decoded
   function automatic logic [CP_W-1:0] next_base(input logic [CP_W-1:0] c);
      logic [CP_W-1:0] r;
      if (c >= 21'h3040 && c <= 21'h309F) begin
         r = 21'h3070;
      end else if (c >= 21'h4E00 && c <= 21'h9FA5) begin
         r = CP_W'(32'h4E00 - NEG_REACH2);
      end else if (c >= 21'hAC00 && c <= 21'hD7A3) begin
         r = CP_W'((32'hD7A3 + 32'hAC00) / 2);
      end else begin
         r = {c[CP_W-1:7], 7'd0} + ASCII_BASE;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/bocu1_front.sv
`timescale 1ns / 1ps
// bocu1_front: takes encoded bytes, tracks trail count and partial difference
// depends on bocu1_pkg
module bocu1_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [bocu1_pkg::BYTE_W-1:0]  code_byte,
   input  logic                          last_of_text,
   output logic                          push,
   output bocu1_pkg::entry_type          entry
);

   localparam int DW = bocu1_pkg::DIFF_W;

   logic [1:0]           trail_ff, trail_in;
   logic signed [DW-1:0] diff_ff, diff_in;

   bocu1_pkg::trail_type tv;
   logic [DW-1:0]        b_ext, t_ext;

   assign tv    = bocu1_pkg::trail_value(code_byte);
   assign b_ext = DW'(code_byte);
   assign t_ext = DW'(tv.val);

   always_comb begin
      push      = 1'b0;
      entry.op  = bocu1_pkg::OP_BASE;
      entry.arg = '0;
      entry.clr = last_of_text;
      trail_in  = trail_ff;
      diff_in   = diff_ff;
      if (accept) begin
         if (trail_ff == 2'd0) begin
            if (code_byte == '0) begin
               push     = 1'b1;
               entry.op = bocu1_pkg::OP_EOT;
            end else if (code_byte <= bocu1_pkg::SPACE_BYTE) begin
               push      = 1'b1;
               entry.op  = bocu1_pkg::OP_CHAR;
               entry.arg = b_ext;
               entry.clr = (code_byte != bocu1_pkg::SPACE_BYTE) || last_of_text;
            end else if (code_byte >= bocu1_pkg::NEG2_LEAD &&
                         code_byte <  bocu1_pkg::POS2_LEAD) begin
               push      = 1'b1;
               entry.op  = bocu1_pkg::OP_DIFF;
               entry.arg = b_ext - DW'(bocu1_pkg::MID_BYTE);
            end else if (code_byte == bocu1_pkg::RESET_BYTE) begin
               push      = 1'b1;
               entry.op  = bocu1_pkg::OP_BASE;
               entry.clr = 1'b1;
            end else if (code_byte >= bocu1_pkg::POS3_LEAD + 8'd3) begin
               // four-byte positive lead
               diff_in  = DW'(bocu1_pkg::POS_REACH3 + 1);
               trail_in = 2'd3;
            end else if (code_byte >= bocu1_pkg::POS3_LEAD) begin
               diff_in  = DW'((b_ext - DW'(bocu1_pkg::POS3_LEAD))
                              * DW'(bocu1_pkg::TRAIL_RADIX2))
                          + DW'(bocu1_pkg::POS_REACH2 + 1);
               trail_in = 2'd2;
            end else if (code_byte >= bocu1_pkg::POS2_LEAD) begin
               diff_in  = DW'((b_ext - DW'(bocu1_pkg::POS2_LEAD))
                              * DW'(bocu1_pkg::TRAIL_RADIX))
                          + DW'(bocu1_pkg::POS_REACH1 + 1);
               trail_in = 2'd1;
            end else if (code_byte >= bocu1_pkg::NEG3_LEAD) begin
               diff_in  = DW'((b_ext - DW'(bocu1_pkg::NEG2_LEAD))
                              * DW'(bocu1_pkg::TRAIL_RADIX))
                          + DW'(bocu1_pkg::NEG_REACH1);
               trail_in = 2'd1;
            end else if (code_byte > bocu1_pkg::MIN_LEAD) begin
               diff_in  = DW'((b_ext - DW'(bocu1_pkg::NEG3_LEAD))
                              * DW'(bocu1_pkg::TRAIL_RADIX2))
                          + DW'(bocu1_pkg::NEG_REACH2);
               trail_in = 2'd2;
            end else begin
               // four-byte negative lead
               diff_in  = DW'(bocu1_pkg::NEG_REACH3 - bocu1_pkg::TRAIL_RADIX3);
               trail_in = 2'd3;
            end
         end else if (!tv.ok) begin
            push     = 1'b1;
            entry.op = bocu1_pkg::OP_ERR;
            trail_in = 2'd0;
            diff_in  = '0;
         end else if (trail_ff == 2'd1) begin
            push      = 1'b1;
            entry.op  = bocu1_pkg::OP_DIFF;
            entry.arg = diff_ff + t_ext;
            trail_in  = 2'd0;
            diff_in   = '0;
         end else if (trail_ff == 2'd2) begin
            diff_in  = diff_ff + DW'(t_ext * DW'(bocu1_pkg::TRAIL_RADIX));
            trail_in = 2'd1;
         end else begin
            diff_in  = diff_ff + DW'(t_ext * DW'(bocu1_pkg::TRAIL_RADIX2));
            trail_in = 2'd2;
         end
         // end of buffer: drop partial state, back resets its base
         if (last_of_text) begin
            trail_in = 2'd0;
            diff_in  = '0;
            if (!push) begin
               push      = 1'b1;
               entry.op  = bocu1_pkg::OP_BASE;
               entry.clr = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trail_ff <= 2'd0;
         diff_ff  <= '0;
      end else begin
         trail_ff <= trail_in;
         diff_ff  <= diff_in;
      end
   end

`ifndef SYNTHESIS
   // no partial difference survives outside a multi-byte sequence
   assert property (@(posedge clock) disable iff (reset)
      trail_ff == 2'd0 |-> diff_ff == '0)
      else $error("partial difference left over");
   // a final trail byte always produces a queue entry
   assert property (@(posedge clock) disable iff (reset)
      accept && trail_ff == 2'd1 |-> push)
      else $error("final trail byte produced no entry");
`endif

endmodule

// File: hw/rtl/bocu1_queue.sv
`timescale 1ns / 1ps
// bocu1_queue: small register queue between the front and the back
// depends on bocu1_pkg
module bocu1_queue #(
   parameter int DEPTH = bocu1_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  bocu1_pkg::entry_type           push_entry,
   input  logic                           pop,
   output bocu1_pkg::entry_type           head,
   output bocu1_pkg::queue_status_type    status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bocu1_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   assign head             = mem_ff[rd_ptr_ff];
   assign status.full      = (count_ff == CNT_W'(DEPTH));
   assign status.not_empty = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset)
      !(pop && !status.not_empty))
      else $error("pop from empty queue");
`endif

endmodule

// File: hw/rtl/bocu1_back.sv
`timescale 1ns / 1ps
// bocu1_back: applies queued operations to the base and registers the result
// depends on bocu1_pkg
module bocu1_back (
   input  logic                           clock,
   input  logic                           reset,
   input  bocu1_pkg::entry_type           head,
   input  bocu1_pkg::queue_status_type    q_status,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bocu1_pkg::CP_W-1:0]     rsp_code_point,
   output logic [bocu1_pkg::STAT_W-1:0]   rsp_status
);

   localparam int CW = bocu1_pkg::CP_W;
   localparam int SW = bocu1_pkg::SUM_W;

   logic [CW-1:0]                  base_ff, base_in;
   logic                           valid_ff, valid_in;
   logic [CW-1:0]                  cp_ff, cp_in;
   logic [bocu1_pkg::STAT_W-1:0]   stat_ff, stat_in;
   logic                           out_free, bad;
   logic [SW-1:0]                  sum;

   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = q_status.not_empty && out_free;

   // base plus signed difference, one bit wider to see the sign
   assign sum = SW'(base_ff) + {head.arg[bocu1_pkg::DIFF_W-1], head.arg};
   assign bad = sum[SW-1] || (sum[SW-2:0] > (SW-1)'(bocu1_pkg::MAX_SCALAR));

   always_comb begin
      base_in  = base_ff;
      valid_in = valid_ff;
      cp_in    = cp_ff;
      stat_in  = stat_ff;
      if (out_free) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         unique case (head.op)
            bocu1_pkg::OP_CHAR: begin
               valid_in = 1'b1;
               cp_in    = CW'(head.arg[bocu1_pkg::BYTE_W-1:0]);
               stat_in  = bocu1_pkg::STATUS_CP;
               if (head.clr) begin
                  base_in = bocu1_pkg::ASCII_BASE;
               end
            end
            bocu1_pkg::OP_EOT: begin
               valid_in = 1'b1;
               cp_in    = '0;
               stat_in  = bocu1_pkg::STATUS_EOT;
               base_in  = bocu1_pkg::ASCII_BASE;
            end
            bocu1_pkg::OP_ERR: begin
               valid_in = 1'b1;
               cp_in    = '0;
               stat_in  = bocu1_pkg::STATUS_ERR;
               base_in  = bocu1_pkg::ASCII_BASE;
            end
            bocu1_pkg::OP_DIFF: begin
               valid_in = 1'b1;
               if (bad) begin
                  cp_in   = '0;
                  stat_in = bocu1_pkg::STATUS_ERR;
                  base_in = bocu1_pkg::ASCII_BASE;
               end else begin
                  cp_in   = sum[CW-1:0];
                  stat_in = bocu1_pkg::STATUS_CP;
                  base_in = head.clr ? bocu1_pkg::ASCII_BASE
                                     : bocu1_pkg::next_base(sum[CW-1:0]);
               end
            end
            default: begin
               base_in = bocu1_pkg::ASCII_BASE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= bocu1_pkg::ASCII_BASE;
         valid_ff <= 1'b0;
      end else begin
         base_ff  <= base_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff   <= cp_in;
      stat_ff <= stat_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_code_point = cp_ff;
   assign rsp_status     = stat_ff;

`ifndef SYNTHESIS
   // anything but a code point carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && stat_ff != bocu1_pkg::STATUS_CP |-> cp_ff == '0)
      else $error("non-character result with nonzero value");
   // a code point result never leaves the unicode range
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && stat_ff == bocu1_pkg::STATUS_CP |-> cp_ff <= bocu1_pkg::MAX_SCALAR)
      else $error("code point out of range");
`endif

endmodule

// File: hw/rtl/bocu1_stream_decoder_unit.sv
`timescale 1ns / 1ps
// bocu1_stream_decoder_unit: top level of the bocu-1 byte stream decoder
// depends on bocu1_pkg, bocu1_front, bocu1_queue, bocu1_back
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+------------------------------------
//   req     | in  | req_valid/req_stall  | req_code_byte, req_last_of_text
//   rsp     | out | rsp_valid/rsp_stall  | rsp_code_point, rsp_status
//
// one byte per cycle sustained while req_stall is low; a transaction that yields a result
// is written to the queue when accepted, then popped by the back, which updates the
// base and registers the result for rsp; older entries or rsp_stall can keep it in the queue
// the base update (add, range compare, next-base select) is the feedback loop through the base register
// synchronous active-high reset clears trail count, difference and queue and sets the base to ASCII_BASE
// req_stall rises only when the queue is full, i.e. when rsp has been stalled
module bocu1_stream_decoder_unit #(
   parameter int QUEUE_DEPTH = bocu1_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bocu1_pkg::BYTE_W-1:0]   req_code_byte,
   input  logic                           req_last_of_text,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bocu1_pkg::CP_W-1:0]     rsp_code_point,
   output logic [bocu1_pkg::STAT_W-1:0]   rsp_status
);

   logic                          accept;
   logic                          push;
   logic                          pop;
   bocu1_pkg::entry_type          push_entry;
   bocu1_pkg::entry_type          head;
   bocu1_pkg::queue_status_type   q_status;

   // stall straight from the queue fill level, never from req_valid
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // front: classifies each byte and folds trail bytes into the difference
   bocu1_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .code_byte    (req_code_byte),
      .last_of_text (req_last_of_text),
      .push         (push),
      .entry        (push_entry)
   );

   // queue: lets the front keep taking transactions while rsp is stalled
   bocu1_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // back: owns the base code point and the output register
   bocu1_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_status     (rsp_status)
   );

endmodule

// File: bench/bocu1_decode_tracker_pkg.sv
`timescale 1ns / 1ps
// bocu1_decode_tracker_pkg: byte-level bocu-1 decode predictor and result checker
// depends on bocu1_pkg for widths, status codes and scheme constants
package bocu1_decode_tracker_pkg;
   import bocu1_pkg::*;

   // script ranges that pin the base to a fixed value
   localparam int KANA_LO   = 'h3040;
   localparam int KANA_HI   = 'h309F;
   localparam int KANA_BASE = 'h3070;
   localparam int HAN_LO    = 'h4E00;
   localparam int HAN_HI    = 'h9FA5;
   localparam int HANGUL_LO = 'hAC00;
   localparam int HANGUL_HI = 'hD7A3;
   localparam int NO_DIGIT  = -1;
   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [CP_W-1:0]   code_point;
      logic [STAT_W-1:0] status;
   } decoded_t;

   class bocu1_decode_tracker;
      decoded_t pending_points[$];
      int       base_point;
      int       diff_sum;
      int       trails_owed;
      int       fault_count;

      function new();
         restart();
         fault_count = 0;
      endfunction

      function void restart();
         base_point  = int'(ASCII_BASE);
         diff_sum    = 0;
         trails_owed = 0;
      endfunction

      function int rebase(int c);
         if (c >= KANA_LO && c <= KANA_HI) return KANA_BASE;
         if (c >= HAN_LO && c <= HAN_HI) return HAN_LO - NEG_REACH2;
         if (c >= HANGUL_LO && c <= HANGUL_HI) return (HANGUL_LO + HANGUL_HI) / 2;
         return (c / 128) * 128 + int'(ASCII_BASE);
      endfunction

      // value of a trail byte; some control codes and space are not allowed as trails
      function int trail_digit(logic [BYTE_W-1:0] b);
         if (b > SPACE_BYTE) return int'(b) - int'(TRAIL_OFS);
         if (b >= 8'h01 && b <= 8'h06) return int'(b) - 1;
         if (b >= 8'h10 && b <= 8'h19) return int'(b) - 10;
         if (b >= 8'h1C && b <= 8'h1F) return int'(b) - 12;
         return NO_DIGIT;
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b, logic last);
         int       c;
         int       d;
         logic     hit;
         decoded_t e;
         hit          = 1'b0;
         e.code_point = '0;
         e.status     = STATUS_CP;
         if (trails_owed == 0) begin
            if (b == 8'h00) begin
               restart();
               e.status = STATUS_EOT;
               hit      = 1'b1;
            end else if (b <= SPACE_BYTE) begin
               if (b != SPACE_BYTE) base_point = int'(ASCII_BASE);
               e.code_point = CP_W'(b);
               hit          = 1'b1;
            end else if (b >= NEG2_LEAD && b < POS2_LEAD) begin
               c            = base_point + int'(b) - int'(MID_BYTE);
               base_point   = rebase(c);
               e.code_point = CP_W'(c);
               hit          = 1'b1;
            end else if (b == RESET_BYTE) begin
               base_point = int'(ASCII_BASE);
            end else if (b >= POS4_LEAD) begin
               diff_sum    = POS_REACH3 + 1;
               trails_owed = 3;
            end else if (b >= POS3_LEAD) begin
               diff_sum    = (int'(b) - int'(POS3_LEAD)) * TRAIL_RADIX2 + POS_REACH2 + 1;
               trails_owed = 2;
            end else if (b >= POS2_LEAD) begin
               diff_sum    = (int'(b) - int'(POS2_LEAD)) * TRAIL_RADIX + POS_REACH1 + 1;
               trails_owed = 1;
            end else if (b >= NEG3_LEAD) begin
               diff_sum    = (int'(b) - int'(NEG2_LEAD)) * TRAIL_RADIX + NEG_REACH1;
               trails_owed = 1;
            end else if (b > MIN_LEAD) begin
               diff_sum    = (int'(b) - int'(NEG3_LEAD)) * TRAIL_RADIX2 + NEG_REACH2;
               trails_owed = 2;
            end else begin
               diff_sum    = -TRAIL_RADIX3 + NEG_REACH3;
               trails_owed = 3;
            end
         end else begin
            d = trail_digit(b);
            if (d == NO_DIGIT) begin
               restart();
               e.status = STATUS_ERR;
               hit      = 1'b1;
            end else if (trails_owed == 1) begin
               c = base_point + diff_sum + d;
               if (c < 0 || c > int'(MAX_SCALAR)) begin
                  restart();
                  e.status = STATUS_ERR;
               end else begin
                  base_point   = rebase(c);
                  diff_sum     = 0;
                  trails_owed  = 0;
                  e.code_point = CP_W'(c);
               end
               hit = 1'b1;
            end else begin
               diff_sum    = diff_sum + d * ((trails_owed == 2) ? TRAIL_RADIX : TRAIL_RADIX2);
               trails_owed = trails_owed - 1;
            end
         end
         if (hit) pending_points.push_back(e);
         if (last) restart();
      endfunction

      task report_fault(string msg);
         if (fault_count < PRINT_CAP) $display("ERROR at %0t: %s", $time, msg);
         fault_count++;
      endtask

      task check_output(logic [CP_W-1:0] cp, logic [STAT_W-1:0] st);
         decoded_t e;
         if (pending_points.size() == 0) begin
            report_fault($sformatf("unexpected result, code point %06h status %0d", cp, st));
            return;
         end
         e = pending_points.pop_front();
         if (st !== e.status)
            report_fault($sformatf("status %0d, %0d expected", st, e.status));
         if (cp !== e.code_point)
            report_fault($sformatf("code point %06h, %06h expected", cp, e.code_point));
      endtask
   endclass

endpackage

// File: bench/bocu1_stream_decoder_unit_tb.sv
`timescale 1ns / 1ps
// bocu1_stream_decoder_unit_tb: directed and random byte streams through the bocu-1 decoder
// depends on bocu1_pkg, bocu1_decode_tracker_pkg and the bocu1_stream_decoder_unit rtl
module bocu1_stream_decoder_unit_tb;
   import bocu1_pkg::*;
   import bocu1_decode_tracker_pkg::*;

   localparam int RANDOM_BYTES = 600;
   localparam int HOLD_CYCLES  = 200;   // long receiver hold-off, fills the queue
   localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
   localparam int DRAIN_CYCLES = 8;     // idle cycles after the last prediction is matched

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [BYTE_W-1:0]  req_code_byte = '0;
   logic               req_last_of_text = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [CP_W-1:0]    rsp_code_point;
   logic [STAT_W-1:0]  rsp_status;

   bocu1_decode_tracker tracker;
   int                  bytes_sent = 0;
   int                  results_taken = 0;
   int                  quiet_cycles = 0;
   bit                  hold_off_request = 1'b0;

   bocu1_stream_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .req_last_of_text (req_last_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_point   (rsp_code_point),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // offer one byte and hold it until the decoder takes it
   // called in the time step of a rising edge; the gap is redrawn per transaction,
   // with every third stretch of fifty bytes sent back to back
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      int gap;
      gap = ((bytes_sent / 50) % 3 == 1) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_code_byte    <= b;
      req_last_of_text <= last;
      // values read right after the edge are those the decoder saw at it
      do @(posedge clock); while (req_stall);
      tracker.note_byte(b, last);
      bytes_sent++;
   endtask

   // one random group: mostly well-formed characters with random content,
   // some control codes, end of text or base resets, the rest raw noise
   task automatic send_random_group();
      int                kind;
      int                trails;
      int                digit;
      logic              upward;
      logic [BYTE_W-1:0] lead;
      kind   = $urandom_range(0, 99);
      upward = 1'($urandom_range(0, 1));
      trails = 0;
      if (kind < 35) begin
         lead = BYTE_W'($urandom_range(NEG2_LEAD, POS2_LEAD - 1));
      end else if (kind < 60) begin
         lead   = upward ? BYTE_W'($urandom_range(POS2_LEAD, POS3_LEAD - 1))
                         : BYTE_W'($urandom_range(NEG3_LEAD, NEG2_LEAD - 1));
         trails = 1;
      end else if (kind < 70) begin
         lead   = upward ? BYTE_W'($urandom_range(POS3_LEAD, POS4_LEAD - 1))
                         : BYTE_W'($urandom_range(MIN_LEAD + 1, NEG3_LEAD - 1));
         trails = 2;
      end else if (kind < 75) begin
         lead   = upward ? POS4_LEAD : MIN_LEAD;
         trails = 3;
      end else if (kind < 85) begin
         // control code or space, now and then end of text or a base reset
         lead = ($urandom_range(0, 15) == 0) ? 8'h00
                                             : BYTE_W'($urandom_range(1, SPACE_BYTE));
         if ($urandom_range(0, 9) == 0) lead = RESET_BYTE;
      end else begin
         repeat ($urandom_range(1, 3))
            send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         return;
      end
      send_byte(lead, $urandom_range(0, 39) == 0);
      for (int k = trails; k > 0; k--) begin
         // four-byte differences only land in range with an extreme top digit
         if (k == 3) digit = upward ? $urandom_range(0, 17) : $urandom_range(225, 242);
         else        digit = $urandom_range(0, TRAIL_RADIX - 1);
         // digit to trail byte: three runs of allowed control codes, then offset bytes
         if (digit < 6)       lead = BYTE_W'(digit + 1);
         else if (digit < 16) lead = BYTE_W'(digit + 10);
         else if (digit < 20) lead = BYTE_W'(digit + 12);
         else                 lead = BYTE_W'(digit + int'(TRAIL_OFS));
         send_byte(lead, $urandom_range(0, 39) == 0);
      end
   endtask

   // receiver: random stall per result, quiet stretches, one long hold-off
   initial begin
      int hold;
      wait (!reset);
      forever begin
         hold = ((results_taken / 40) % 4 == 2) ? 0 : $urandom_range(0, 6);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold             = HOLD_CYCLES;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         results_taken++;
      end
   end

   // result monitor: every accepted transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_output(rsp_code_point, rsp_status);
   end

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d predicted results outstanding",
                     tracker.pending_points.size());
            $display("bocu1_stream_decoder_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int directed_done;
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // hiragana: three-byte positive difference, then a single byte from the kana base
      send_byte(8'hFB, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'h67, 1'b0);
      send_byte(MID_BYTE, 1'b0);
      // unihan via a two-byte positive difference
      send_byte(8'hEE, 1'b0);
      send_byte(8'hE3, 1'b0);
      send_byte(MID_BYTE, 1'b0);
      // hangul via a three-byte difference with a control-code trail
      send_byte(8'hFB, 1'b0);
      send_byte(8'h16, 1'b0);
      send_byte(8'h87, 1'b0);
      send_byte(MID_BYTE, 1'b0);
      // end of text, a c0 control that resets the base, space
      send_byte(8'h00, 1'b0);
      send_byte(8'h0A, 1'b0);
      send_byte(SPACE_BYTE, 1'b0);
      // single-byte extremes, the top one marked last of text
      send_byte(POS2_LEAD - 8'd1, 1'b1);
      send_byte(NEG2_LEAD, 1'b0);
      // base reset without a result
      send_byte(RESET_BYTE, 1'b0);
      // zero byte in trail position is illegal
      send_byte(POS2_LEAD, 1'b0);
      send_byte(8'h00, 1'b0);
      // four-byte differences out of range upwards and downwards
      send_byte(POS4_LEAD, 1'b0);
      repeat (3) send_byte(RESET_BYTE, 1'b0);
      send_byte(MIN_LEAD, 1'b0);
      repeat (3) send_byte(8'h01, 1'b0);

      // random part; the receiver takes its long hold-off early on
      directed_done    = bytes_sent;
      hold_off_request = 1'b1;
      while (bytes_sent < directed_done + RANDOM_BYTES) send_random_group();
      req_valid <= 1'b0;

      while (tracker.pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.fault_count == 0) $display("bocu1_stream_decoder_unit: match");
      else $display("bocu1_stream_decoder_unit: mismatch");
      $finish;
   end

endmodule
